FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the codec RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/b64c_pkg.sv
// Shared types and constants of the base64 codec.
// No dependencies; used by the front end, queue, back end and core.
package b64c_pkg;

	// Pad character '='
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Result status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;

	// What the back end does with one group
	typedef enum logic [1:0] {
		JOB_ENC,
		JOB_DEC,
		JOB_ERR
	} job_kind_t;

	// One finished group, front to back
	typedef struct packed {
		job_kind_t   kind;
		logic [23:0] bits;
		logic [1:0]  n_m1;    // number of results minus one
		logic [1:0]  pads;    // encode: trailing '=' count
		logic        msg_end; // group closes the message
		logic [1:0]  status;
	} job_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/core/b64c_if.sv
// Valid/ready channel interfaces of the base64 codec.
// Input carries one byte or character, output one result.
interface b64c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_end;
	logic [1:0] out_status;

	modport source (output valid, output out_byte, output out_last, output out_end,
		output out_status, input ready);
	modport sink   (input valid, input out_byte, input out_last, input out_end,
		input out_status, output ready);
endinterface

FILE: rtl/core/b64c_front.sv
// Front end: takes requests, gathers groups, classifies them into jobs.
// Depends on b64c_pkg and b64c_in_if.
module b64c_front (
	input  logic                clk,
	input  logic                arst_n,
	b64c_in_if.sink             item,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  b64c_pkg::q_stat_t   q_stat,
	output logic                push,
	output b64c_pkg::job_t      job
);

	logic        dir_q;
	logic [1:0]  grp_cnt_q;
	logic [23:0] grp_bits_q;
	logic [1:0]  pad_q;
	logic        bad_q;

	logic        accept;
	logic [6:0]  cv;
	logic [5:0]  dval;
	logic        dbad;
	logic [23:0] enc_bits;
	logic [23:0] dec_bits;
	logic [1:0]  pad_n;
	logic        bad_n;
	logic        done;
	logic [1:0]  nxt_cnt;

	// Six-bit value of a character, bad flag on top
	function automatic logic [6:0] char_val(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A)
			r = {1'b0, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A)
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B)
			r = {1'b0, 6'd62};
		else if (c == 8'h2F)
			r = {1'b0, 6'd63};
		else if (c == b64c_pkg::PAD_CHAR)
			r = 7'd0;
		else
			r = {1'b1, 6'd0};
		return r;
	endfunction

	assign item.ready = !q_stat.full;
	assign accept     = item.valid && item.ready;

	assign cv   = char_val(item.in_byte);
	assign dval = cv[5:0];
	assign dbad = cv[6];

	// Merge the new item into the group
	always_comb begin
		enc_bits = grp_bits_q;
		dec_bits = grp_bits_q;
		pad_n    = pad_q;
		case (grp_cnt_q)
			2'd0: begin
				enc_bits[23:16] = grp_bits_q[23:16] | item.in_byte;
				dec_bits[23:18] = grp_bits_q[23:18] | dval;
			end
			2'd1: begin
				enc_bits[15:8]  = grp_bits_q[15:8] | item.in_byte;
				dec_bits[17:12] = grp_bits_q[17:12] | dval;
			end
			2'd2: begin
				enc_bits[7:0]   = grp_bits_q[7:0] | item.in_byte;
				dec_bits[11:6]  = grp_bits_q[11:6] | dval;
				if (item.in_byte == b64c_pkg::PAD_CHAR) pad_n[0] = 1'b1;
			end
			default: begin
				enc_bits[7:0]   = grp_bits_q[7:0] | item.in_byte;
				dec_bits[5:0]   = grp_bits_q[5:0] | dval;
				if (item.in_byte == b64c_pkg::PAD_CHAR) pad_n[1] = 1'b1;
			end
		endcase
		bad_n = bad_q | dbad;
	end

	// Classify: does this item close a group, and what job results
	always_comb begin
		job.kind    = b64c_pkg::JOB_ENC;
		job.bits    = enc_bits;
		job.n_m1    = 2'd3;
		job.pads    = 2'd0;
		job.msg_end = item.in_last;
		job.status  = b64c_pkg::ST_OK;
		done        = 1'b0;
		nxt_cnt     = grp_cnt_q + 2'd1;
		if (!dir_q) begin
			// encode: close at the third byte or at the message end
			done = (grp_cnt_q >= 2'd2) || item.in_last;
			case (grp_cnt_q)
				2'd0:    job.pads = 2'd2;
				2'd1:    job.pads = 2'd1;
				default: job.pads = 2'd0;
			endcase
		end else if (grp_cnt_q != 2'd3) begin
			// decode mid-group: a message end here is a length error
			done        = item.in_last;
			job.kind    = b64c_pkg::JOB_ERR;
			job.bits    = 24'd0;
			job.n_m1    = 2'd0;
			job.msg_end = 1'b1;
			job.status  = b64c_pkg::ST_LEN;
		end else begin
			done        = 1'b1;
			job.kind    = b64c_pkg::JOB_DEC;
			job.bits    = dec_bits;
			job.n_m1    = item.in_last ? 2'(2'd2 - {1'b0, pad_n[0]} - {1'b0, pad_n[1]})
				: 2'd2;
			job.status  = bad_n ? b64c_pkg::ST_BAD : b64c_pkg::ST_OK;
		end
	end

	assign push = accept && done;

	// Direction and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 1'b0;
			grp_cnt_q  <= 2'd0;
			grp_bits_q <= 24'd0;
			pad_q      <= 2'd0;
			bad_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			dir_q      <= cfg_wr_data;
			grp_cnt_q  <= 2'd0;
			grp_bits_q <= 24'd0;
			pad_q      <= 2'd0;
			bad_q      <= 1'b0;
		end else if (accept) begin
			if (done) begin
				grp_cnt_q  <= 2'd0;
				grp_bits_q <= 24'd0;
				pad_q      <= 2'd0;
				bad_q      <= 1'b0;
			end else begin
				grp_cnt_q  <= nxt_cnt;
				grp_bits_q <= dir_q ? dec_bits : enc_bits;
				pad_q      <= pad_n;
				bad_q      <= dir_q ? bad_n : 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/b64c_queue.sv
// Short job queue between front and back end.
// Depends on b64c_pkg.
module b64c_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64c_pkg::job_t    wr_job,
	input  logic              pop,
	output b64c_pkg::job_t    head,
	output b64c_pkg::q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64c_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/b64c_back.sv
// Back end: expands one job into its results, one per cycle while the queue holds a job and the receiver is ready.
// Depends on b64c_pkg and b64c_out_if.
module b64c_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64c_pkg::job_t    head,
	input  b64c_pkg::q_stat_t q_stat,
	output logic              pop,
	b64c_out_if.source        result
);

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       end_q;
	logic [1:0] status_q;

	logic       load;
	logic       fin;
	logic [5:0] six;
	logic [7:0] res_byte;

	// Alphabet lookup
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26)      r = 8'(8'h41 + {2'b00, v});
		else if (v < 6'd52) r = 8'(8'h61 + {2'b00, v} - 8'd26);
		else if (v < 6'd62) r = 8'(8'h30 + {2'b00, v} - 8'd52);
		else if (v == 6'd62) r = 8'h2B;
		else                 r = 8'h2F;
		return r;
	endfunction

	assign load = !q_stat.empty && (!vld_q || result.ready);
	assign fin  = (idx_q == head.n_m1);
	assign pop  = load && fin;

	// Select the six bits and byte for this result
	always_comb begin
		case (idx_q)
			2'd0:    six = head.bits[23:18];
			2'd1:    six = head.bits[17:12];
			2'd2:    six = head.bits[11:6];
			default: six = head.bits[5:0];
		endcase
		case (head.kind)
			b64c_pkg::JOB_ENC: begin
				if ((head.pads == 2'd2 && idx_q >= 2'd2) || (head.pads == 2'd1 && idx_q == 2'd3))
					res_byte = b64c_pkg::PAD_CHAR;
				else
					res_byte = enc_char(six);
			end
			b64c_pkg::JOB_DEC: begin
				case (idx_q)
					2'd0:    res_byte = head.bits[23:16];
					2'd1:    res_byte = head.bits[15:8];
					default: res_byte = head.bits[7:0];
				endcase
			end
			default: res_byte = 8'd0;
		endcase
	end

	// Result index within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			vld_q <= 1'b0;
		end else begin
			if (load) idx_q <= fin ? 2'd0 : 2'(idx_q + 2'd1);
			if (load)              vld_q <= 1'b1;
			else if (result.ready) vld_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= res_byte;
			last_q   <= fin;
			end_q    <= fin && head.msg_end;
			status_q <= head.status;
		end
	end

	assign result.valid      = vld_q;
	assign result.out_byte   = byte_q;
	assign result.out_last   = last_q;
	assign result.out_end    = end_q;
	assign result.out_status = status_q;

endmodule

FILE: rtl/core/base64_codec_core.sv
// Streaming base64 encoder/decoder, direction set by a one-bit register.
// A group's job is written into the queue by the request that closes it; its results leave through an output register.
// Throughput: one result per cycle from the back end while the receiver is ready;
// the job queue holds QUEUE_DEPTH groups.
// Reset (arst_n low, async): direction is encode, group state and queue cleared.
// Depends on b64c_pkg, b64c_if, b64c_front, b64c_queue, b64c_back, assert_macros.svh.
`include "assert_macros.svh"

module base64_codec_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	b64c_in_if.sink     item,
	b64c_out_if.source  result,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	logic              push;
	logic              pop;
	b64c_pkg::job_t    new_job;
	b64c_pkg::job_t    head;
	b64c_pkg::q_stat_t q_stat;

	// Accept and classify
	b64c_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.push        (push),
		.job         (new_job)
	);

	// Decoupling queue
	b64c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (new_job),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	// Expand and emit
	b64c_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

	// Checks
	`CHK_SAME(a_end_is_last, result.valid && result.out_end, result.out_last, "end without last")
	`CHK_SAME(a_len_err_form, result.valid && result.out_status == b64c_pkg::ST_LEN, result.out_end && result.out_byte == 8'd0, "bad length error result")
	`CHK_SAME(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
	`CHK_NEXT(a_push_fills, push && !pop, !q_stat.empty, "queue empty after push")

endmodule
